>>> hdl/sma_pkg.sv
// ----------------------------------------------------------------------------
// sma_pkg: shared types and constants of the stack machine ALU
// Opcodes, microcode word layout, control and flag bundles, microcode table.
// ----------------------------------------------------------------------------
package sma_pkg;

	localparam int DEPTH     = 1024;
	localparam int ADDR_W    = $clog2(DEPTH);
	localparam int COUNT_W   = 11;
	localparam int WORD_W    = 32;
	localparam int CMD_W     = 4;
	localparam int STATUS_W  = 2;
	localparam int DIV_STEPS = WORD_W;
	localparam int DIV_CNT_W = $clog2(DIV_STEPS);
	localparam int PC_W      = 5;

	typedef logic [WORD_W-1:0]  word_t;
	typedef logic [COUNT_W-1:0] count_t;
	typedef logic [ADDR_W-1:0]  addr_t;
	typedef logic [PC_W-1:0]    pc_t;

	typedef enum logic [CMD_W-1:0] {
		OP_CONST = 4'd0,
		OP_ADD   = 4'd1,
		OP_SUB   = 4'd2,
		OP_MUL   = 4'd3,
		OP_DIV   = 4'd4,
		OP_MAX   = 4'd5,
		OP_MIN   = 4'd6,
		OP_NEG   = 4'd7,
		OP_DUP   = 4'd8,
		OP_SWAP  = 4'd9,
		OP_END   = 4'd10
	} op_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK    = 2'd0,
		ST_UNDER = 2'd1,
		ST_OVER  = 2'd2,
		ST_DIV0  = 2'd3
	} status_t;

	typedef enum logic {
		ST_IDLE,
		ST_RUN
	} state_t;

	// Write address select: the spill slot of the top, or the entry below it.
	typedef enum logic {
		WSEL_N1,
		WSEL_N2
	} wsel_t;

	typedef enum logic [2:0] {
		TSEL_KEEP,
		TSEL_IMM,
		TSEL_ALU,
		TSEL_RD,
		TSEL_NEG,
		TSEL_DIV
	} tsel_t;

	typedef enum logic [1:0] {
		CNT_KEEP,
		CNT_INC,
		CNT_DEC
	} cop_t;

	typedef enum logic [1:0] {
		BR_NEXT,
		BR_DONE,
		BR_WAIT,
		BR_ZERO
	} br_t;

	typedef struct packed {
		logic    rd;
		logic    wr;
		wsel_t   wsel;
		tsel_t   tsel;
		cop_t    cop;
		logic    div_go;
		br_t     br;
		pc_t     target;
		status_t status;
	} uword_t;

	typedef struct packed {
		logic    rd;
		logic    wr;
		wsel_t   wsel;
		tsel_t   tsel;
		cop_t    cop;
		logic    div_go;
		logic    emit;
		status_t status;
		logic    is_end;
		op_t     op;
		word_t   imm;
	} ctrl_t;

	typedef struct packed {
		logic empty;
		logic lt2;
		logic full;
		logic rd_zero;
		logic div_done;
		logic out_busy;
	} flags_t;

	// Microcode addresses.
	localparam pc_t PC_OK       = 5'd0;
	localparam pc_t PC_UNDER    = 5'd1;
	localparam pc_t PC_OVER     = 5'd2;
	localparam pc_t PC_CONST    = 5'd3;
	localparam pc_t PC_BIN_RD   = 5'd4;
	localparam pc_t PC_BIN_EX   = 5'd5;
	localparam pc_t PC_DIV_RD   = 5'd6;
	localparam pc_t PC_DIV_CHK  = 5'd7;
	localparam pc_t PC_DIV_GO   = 5'd8;
	localparam pc_t PC_DIV_WAIT = 5'd9;
	localparam pc_t PC_DIV_WB   = 5'd10;
	localparam pc_t PC_DIV0     = 5'd11;
	localparam pc_t PC_NEG      = 5'd12;
	localparam pc_t PC_DUP      = 5'd13;
	localparam pc_t PC_SWAP_RD  = 5'd14;
	localparam pc_t PC_SWAP_WB  = 5'd15;
	localparam pc_t PC_END_RD   = 5'd16;
	localparam pc_t PC_END_WB   = 5'd17;

	function automatic uword_t uw(
		input logic    rd,
		input logic    wr,
		input wsel_t   wsel,
		input tsel_t   tsel,
		input cop_t    cop,
		input logic    div_go,
		input br_t     br,
		input pc_t     target,
		input status_t status
	);
		uword_t w;
		w.rd     = rd;
		w.wr     = wr;
		w.wsel   = wsel;
		w.tsel   = tsel;
		w.cop    = cop;
		w.div_go = div_go;
		w.br     = br;
		w.target = target;
		w.status = status;
		return w;
	endfunction

	// Microcode table. The top of stack lives in a register; the memory holds
	// the entries below it, so a push spills the old top and a pop refills it.
	function automatic uword_t sma_rom(input pc_t pc);
		uword_t w;
		unique case (pc)
			PC_OK:       w = uw(1'b0, 1'b0, WSEL_N1, TSEL_KEEP, CNT_KEEP, 1'b0, BR_DONE,
						PC_OK, ST_OK);
			PC_UNDER:    w = uw(1'b0, 1'b0, WSEL_N1, TSEL_KEEP, CNT_KEEP, 1'b0, BR_DONE,
						PC_OK, ST_UNDER);
			PC_OVER:     w = uw(1'b0, 1'b0, WSEL_N1, TSEL_KEEP, CNT_KEEP, 1'b0, BR_DONE,
						PC_OK, ST_OVER);
			PC_CONST:    w = uw(1'b0, 1'b1, WSEL_N1, TSEL_IMM, CNT_INC, 1'b0, BR_DONE,
						PC_OK, ST_OK);
			PC_BIN_RD:   w = uw(1'b1, 1'b0, WSEL_N1, TSEL_KEEP, CNT_KEEP, 1'b0, BR_NEXT,
						PC_OK, ST_OK);
			PC_BIN_EX:   w = uw(1'b0, 1'b0, WSEL_N1, TSEL_ALU, CNT_DEC, 1'b0, BR_DONE,
						PC_OK, ST_OK);
			PC_DIV_RD:   w = uw(1'b1, 1'b0, WSEL_N1, TSEL_KEEP, CNT_KEEP, 1'b0, BR_NEXT,
						PC_OK, ST_OK);
			PC_DIV_CHK:  w = uw(1'b0, 1'b0, WSEL_N1, TSEL_KEEP, CNT_KEEP, 1'b0, BR_ZERO,
						PC_DIV0, ST_OK);
			PC_DIV_GO:   w = uw(1'b0, 1'b0, WSEL_N1, TSEL_KEEP, CNT_KEEP, 1'b1, BR_NEXT,
						PC_OK, ST_OK);
			PC_DIV_WAIT: w = uw(1'b0, 1'b0, WSEL_N1, TSEL_KEEP, CNT_KEEP, 1'b0, BR_WAIT,
						PC_OK, ST_OK);
			PC_DIV_WB:   w = uw(1'b0, 1'b0, WSEL_N1, TSEL_DIV, CNT_DEC, 1'b0, BR_DONE,
						PC_OK, ST_OK);
			PC_DIV0:     w = uw(1'b0, 1'b0, WSEL_N1, TSEL_KEEP, CNT_KEEP, 1'b0, BR_DONE,
						PC_OK, ST_DIV0);
			PC_NEG:      w = uw(1'b0, 1'b0, WSEL_N1, TSEL_NEG, CNT_KEEP, 1'b0, BR_DONE,
						PC_OK, ST_OK);
			PC_DUP:      w = uw(1'b0, 1'b1, WSEL_N1, TSEL_KEEP, CNT_INC, 1'b0, BR_DONE,
						PC_OK, ST_OK);
			PC_SWAP_RD:  w = uw(1'b1, 1'b0, WSEL_N1, TSEL_KEEP, CNT_KEEP, 1'b0, BR_NEXT,
						PC_OK, ST_OK);
			PC_SWAP_WB:  w = uw(1'b0, 1'b1, WSEL_N2, TSEL_RD, CNT_KEEP, 1'b0, BR_DONE,
						PC_OK, ST_OK);
			PC_END_RD:   w = uw(1'b1, 1'b0, WSEL_N1, TSEL_KEEP, CNT_KEEP, 1'b0, BR_NEXT,
						PC_OK, ST_OK);
			PC_END_WB:   w = uw(1'b0, 1'b0, WSEL_N1, TSEL_RD, CNT_DEC, 1'b0, BR_DONE,
						PC_OK, ST_OK);
			default:     w = uw(1'b0, 1'b0, WSEL_N1, TSEL_KEEP, CNT_KEEP, 1'b0, BR_DONE,
						PC_OK, ST_OK);
		endcase
		return w;
	endfunction

endpackage

>>> hdl/sma_if.sv
// ----------------------------------------------------------------------------
// sma_if: instruction and result channels of the stack machine ALU
// Valid/ready channels; a transfer happens when valid and ready are both high.
// ----------------------------------------------------------------------------
interface sma_req_if;
	logic                        valid;
	logic                        ready;
	logic [sma_pkg::CMD_W-1:0]   cmd;
	logic signed [sma_pkg::WORD_W-1:0] immediate;

	modport source(output valid, output cmd, output immediate, input ready);
	modport sink(input valid, input cmd, input immediate, output ready);
endinterface

interface sma_rsp_if;
	logic                          valid;
	logic                          ready;
	logic signed [sma_pkg::WORD_W-1:0]   value;
	logic [sma_pkg::COUNT_W-1:0]   count;
	logic [sma_pkg::STATUS_W-1:0]  status;
	logic                          is_end;

	modport source(output valid, output value, output count, output status,
		output is_end, input ready);
	modport sink(input valid, input value, input count, input status,
		input is_end, output ready);
endinterface

>>> hdl/sma_seq.sv
// ----------------------------------------------------------------------------
// sma_seq: microcode sequencer
// Takes one instruction, dispatches to its routine and steps the program.
// ----------------------------------------------------------------------------
module sma_seq (
	input  logic             clk,
	input  logic             arst_n,
	sma_req_if.sink          req,
	input  sma_pkg::flags_t  flags,
	output sma_pkg::ctrl_t   ctrl
);

	sma_pkg::state_t state_q, state_d;
	sma_pkg::pc_t    pc_q, pc_d;
	sma_pkg::pc_t    entry;
	sma_pkg::op_t    op_q;
	sma_pkg::word_t  imm_q;
	sma_pkg::uword_t w;
	logic            accept;
	logic            run;
	logic            stall;
	logic            en;

	assign w      = sma_pkg::sma_rom(pc_q);
	assign accept = req.valid && req.ready;
	assign run    = (state_q == sma_pkg::ST_RUN);
	// A finishing step waits while the previous result still sits in the output.
	assign stall  = (w.br == sma_pkg::BR_DONE) && flags.out_busy;
	assign en     = run && !stall;

	// Entry point; stack depth checks happen here so the routines stay short.
	always_comb begin
		unique case (sma_pkg::op_t'(req.cmd))
			sma_pkg::OP_CONST: entry = flags.full ? sma_pkg::PC_OVER : sma_pkg::PC_CONST;
			sma_pkg::OP_ADD, sma_pkg::OP_SUB, sma_pkg::OP_MUL, sma_pkg::OP_MAX,
			sma_pkg::OP_MIN:   entry = flags.lt2 ? sma_pkg::PC_UNDER : sma_pkg::PC_BIN_RD;
			sma_pkg::OP_DIV:   entry = flags.lt2 ? sma_pkg::PC_UNDER : sma_pkg::PC_DIV_RD;
			sma_pkg::OP_NEG:   entry = flags.empty ? sma_pkg::PC_UNDER : sma_pkg::PC_NEG;
			sma_pkg::OP_DUP: begin
				if (flags.empty) begin
					entry = sma_pkg::PC_UNDER;
				end else if (flags.full) begin
					entry = sma_pkg::PC_OVER;
				end else begin
					entry = sma_pkg::PC_DUP;
				end
			end
			sma_pkg::OP_SWAP:  entry = flags.lt2 ? sma_pkg::PC_UNDER : sma_pkg::PC_SWAP_RD;
			sma_pkg::OP_END:   entry = flags.empty ? sma_pkg::PC_UNDER : sma_pkg::PC_END_RD;
			default:           entry = sma_pkg::PC_OK;
		endcase
	end

	// Next state and program counter.
	always_comb begin
		state_d = state_q;
		pc_d    = pc_q;
		unique case (state_q)
			sma_pkg::ST_IDLE: begin
				if (accept) begin
					state_d = sma_pkg::ST_RUN;
					pc_d    = entry;
				end
			end
			sma_pkg::ST_RUN: begin
				if (en) begin
					unique case (w.br)
						sma_pkg::BR_NEXT: pc_d = pc_q + 1'b1;
						sma_pkg::BR_DONE: state_d = sma_pkg::ST_IDLE;
						sma_pkg::BR_WAIT: pc_d = flags.div_done ? pc_q + 1'b1 : pc_q;
						sma_pkg::BR_ZERO: pc_d = flags.rd_zero ? w.target : pc_q + 1'b1;
						default:          pc_d = pc_q;
					endcase
				end
			end
			default: state_d = sma_pkg::ST_IDLE;
		endcase
	end

	// Outputs.
	always_comb begin
		req.ready   = (state_q == sma_pkg::ST_IDLE);
		ctrl.rd     = en && w.rd;
		ctrl.wr     = en && w.wr;
		ctrl.wsel   = w.wsel;
		ctrl.tsel   = en ? w.tsel : sma_pkg::TSEL_KEEP;
		ctrl.cop    = en ? w.cop : sma_pkg::CNT_KEEP;
		ctrl.div_go = en && w.div_go;
		ctrl.emit   = en && (w.br == sma_pkg::BR_DONE);
		ctrl.status = w.status;
		ctrl.is_end = (op_q == sma_pkg::OP_END);
		ctrl.op     = op_q;
		ctrl.imm    = imm_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sma_pkg::ST_IDLE;
			pc_q    <= sma_pkg::PC_OK;
		end else begin
			state_q <= state_d;
			pc_q    <= pc_d;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q  <= sma_pkg::op_t'(req.cmd);
			imm_q <= req.immediate;
		end
	end

endmodule

>>> hdl/sma_div.sv
// ----------------------------------------------------------------------------
// sma_div: iterative signed divider
// Restoring division on magnitudes, one quotient bit per cycle, truncating.
// ----------------------------------------------------------------------------
module sma_div (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            go,
	input  sma_pkg::word_t  dividend,
	input  sma_pkg::word_t  divisor,
	output logic            done,
	output sma_pkg::word_t  quotient
);

	logic                          busy_q;
	logic                          done_q;
	logic [sma_pkg::DIV_CNT_W-1:0] cnt_q;
	sma_pkg::word_t                rem_q;
	sma_pkg::word_t                dvd_q;
	sma_pkg::word_t                dvs_q;
	logic                          neg_q;
	logic [sma_pkg::WORD_W:0]      shifted;
	logic [sma_pkg::WORD_W+1:0]    diff;
	logic                          fits;

	assign shifted = {rem_q, dvd_q[sma_pkg::WORD_W-1]};
	assign diff    = {1'b0, shifted} - {2'b00, dvs_q};
	assign fits    = !diff[sma_pkg::WORD_W+1];

	assign done     = done_q;
	assign quotient = neg_q ? (sma_pkg::WORD_W'(0) - dvd_q) : dvd_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (go) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == sma_pkg::DIV_CNT_W'(sma_pkg::DIV_STEPS - 1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	// The quotient bits shift into the dividend register as it empties.
	always_ff @(posedge clk) begin
		if (go) begin
			rem_q <= '0;
			dvd_q <= dividend[sma_pkg::WORD_W-1] ? (sma_pkg::WORD_W'(0) - dividend) : dividend;
			dvs_q <= divisor[sma_pkg::WORD_W-1] ? (sma_pkg::WORD_W'(0) - divisor) : divisor;
			neg_q <= dividend[sma_pkg::WORD_W-1] ^ divisor[sma_pkg::WORD_W-1];
		end else if (busy_q) begin
			rem_q <= fits ? diff[sma_pkg::WORD_W-1:0] : shifted[sma_pkg::WORD_W-1:0];
			dvd_q <= {dvd_q[sma_pkg::WORD_W-2:0], fits};
		end
	end

endmodule

>>> hdl/sma_dp.sv
// ----------------------------------------------------------------------------
// sma_dp: stack datapath
// Stack memory, top-of-stack register, ALU, entry count and result register.
// ----------------------------------------------------------------------------
module sma_dp (
	input  logic             clk,
	input  logic             arst_n,
	input  sma_pkg::ctrl_t   ctrl,
	output sma_pkg::flags_t  flags,
	sma_rsp_if.source        rsp
);

	sma_pkg::word_t  mem_q [sma_pkg::DEPTH];
	sma_pkg::word_t  rd_data_q;
	sma_pkg::word_t  top_q, top_d;
	sma_pkg::count_t count_q, count_d;
	sma_pkg::addr_t  addr_n1;
	sma_pkg::addr_t  addr_n2;
	sma_pkg::addr_t  waddr;
	logic            wr_en;
	sma_pkg::word_t  alu_r;
	sma_pkg::word_t  div_q;
	logic            div_done;
	logic            out_valid_q;

	// The memory holds the entries below the top; the top itself is in top_q.
	assign addr_n1 = count_q[sma_pkg::ADDR_W-1:0] - 1'b1;
	assign addr_n2 = count_q[sma_pkg::ADDR_W-1:0] - 2'd2;
	assign waddr   = (ctrl.wsel == sma_pkg::WSEL_N2) ? addr_n2 : addr_n1;
	// A push onto an empty stack has no old top to spill.
	assign wr_en   = ctrl.wr && ((ctrl.wsel == sma_pkg::WSEL_N2) || (count_q != '0));

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[waddr] <= top_q;
		end
		if (ctrl.rd) begin
			rd_data_q <= mem_q[addr_n2];
		end
	end

	sma_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.go       (ctrl.div_go),
		.dividend (top_q),
		.divisor  (rd_data_q),
		.done     (div_done),
		.quotient (div_q)
	);

	// a is the top, b the entry below it.
	always_comb begin
		unique case (ctrl.op)
			sma_pkg::OP_SUB: alu_r = top_q - rd_data_q;
			sma_pkg::OP_MUL: alu_r = top_q * rd_data_q;
			sma_pkg::OP_MAX: alu_r = ($signed(top_q) > $signed(rd_data_q)) ? top_q : rd_data_q;
			sma_pkg::OP_MIN: alu_r = ($signed(rd_data_q) > $signed(top_q)) ? top_q : rd_data_q;
			default:         alu_r = top_q + rd_data_q;
		endcase
	end

	always_comb begin
		unique case (ctrl.tsel)
			sma_pkg::TSEL_IMM: top_d = ctrl.imm;
			sma_pkg::TSEL_ALU: top_d = alu_r;
			sma_pkg::TSEL_RD:  top_d = rd_data_q;
			sma_pkg::TSEL_NEG: top_d = sma_pkg::WORD_W'(0) - top_q;
			sma_pkg::TSEL_DIV: top_d = div_q;
			default:           top_d = top_q;
		endcase
	end

	always_comb begin
		unique case (ctrl.cop)
			sma_pkg::CNT_INC: count_d = count_q + 1'b1;
			sma_pkg::CNT_DEC: count_d = count_q - 1'b1;
			default:          count_d = count_q;
		endcase
	end

	always_ff @(posedge clk) begin
		top_q <= top_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else begin
			count_q <= count_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctrl.emit) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// END gives the popped top, 0 on error; others the new top, 0 if empty.
	always_ff @(posedge clk) begin
		if (ctrl.emit) begin
			if (ctrl.is_end) begin
				rsp.value <= (ctrl.status == sma_pkg::ST_OK) ? top_q : '0;
			end else begin
				rsp.value <= (count_d == '0) ? '0 : top_d;
			end
			rsp.count  <= count_d;
			rsp.status <= ctrl.status;
			rsp.is_end <= ctrl.is_end;
		end
	end

	assign rsp.valid = out_valid_q;

	always_comb begin
		flags.empty    = (count_q == '0);
		flags.lt2      = (count_q < sma_pkg::COUNT_W'(2));
		flags.full     = (count_q == sma_pkg::COUNT_W'(sma_pkg::DEPTH));
		flags.rd_zero  = (rd_data_q == '0);
		flags.div_done = div_done;
		flags.out_busy = out_valid_q && !rsp.ready;
	end

endmodule

>>> hdl/stack_machine_alu_unit.sv
// With the result side ready, CONST, NEG, DUP, unused opcodes and underflow or overflow
// finish at their entry step; ADD, SUB, MUL, MAX, MIN, SWAP and END first read the stack
// memory, and DIV reads, checks the divisor for zero (going to a DIV0 step if so), starts the divider
// and waits on it. A new instruction is taken only once the routine of the last one has ended,
// so DIV mostly waits on the bit-serial divider; a result not yet taken stalls the last step.
// Reset empties the stack and clears the sequencer; memory contents are not cleared.
// ----------------------------------------------------------------------------
// stack_machine_alu_unit: microcoded stack machine ALU
// One instruction in, one result out, on a stack of signed 32-bit words.
// ----------------------------------------------------------------------------
module stack_machine_alu_unit (
	input  logic      clk,
	input  logic      arst_n,
	sma_req_if.sink   req,
	sma_rsp_if.source rsp
);

	sma_pkg::ctrl_t  ctrl;
	sma_pkg::flags_t flags;

	sma_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.flags  (flags),
		.ctrl   (ctrl)
	);

	sma_dp u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (ctrl),
		.flags  (flags),
		.rsp    (rsp)
	);

endmodule
